### src/rmq_pkg.sv
// Package: pivot select codes shared by the rotation matrix to quaternion converter.
`default_nettype none
package rmq_pkg;
    typedef logic [1:0] sel_t;
    localparam sel_t SEL_X = 2'd0;
    localparam sel_t SEL_Y = 2'd1;
    localparam sel_t SEL_Z = 2'd2;
    localparam sel_t SEL_W = 2'd3;
    localparam int LANES = 3;
endpackage
`default_nettype wire

### src/rotation_matrix_to_quaternion.sv
// Top level: pipelined rotation matrix to quaternion converter.
`default_nettype none
// Converts one 3x3 rotation matrix word per clock into a quaternion (qx, qy, qz, qw),
// all fields signed fixed point with FRAC_BITS fraction bits. A word is taken on any
// edge where start is high; busy never rises, so a new matrix may enter every cycle.
// The result appears on the output ports for one cycle with done high. The root
// is SQW bits wide (half the bits of the scaled radicand, 17 at the defaults).
// The pipeline is the input stage, a bit-per-stage square root, a prep stage,
// three bit-per-stage restoring dividers that run side by side and the output
// stage. The receiver cannot stall:
// each result must be taken in the cycle it is shown. degenerate is high with all
// components zero when the chosen radicand is not positive; components saturate.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire signed [DATA_WIDTH-1:0] r00,
    input  wire signed [DATA_WIDTH-1:0] r01,
    input  wire signed [DATA_WIDTH-1:0] r02,
    input  wire signed [DATA_WIDTH-1:0] r10,
    input  wire signed [DATA_WIDTH-1:0] r11,
    input  wire signed [DATA_WIDTH-1:0] r12,
    input  wire signed [DATA_WIDTH-1:0] r20,
    input  wire signed [DATA_WIDTH-1:0] r21,
    input  wire signed [DATA_WIDTH-1:0] r22,
    output logic                        done,
    output logic signed [DATA_WIDTH-1:0] qx,
    output logic signed [DATA_WIDTH-1:0] qy,
    output logic signed [DATA_WIDTH-1:0] qz,
    output logic signed [DATA_WIDTH-1:0] qw,
    output logic                        degenerate
);
    import rmq_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    // unsigned width that holds any positive radicand
    localparam int RADW = ((W + 2 > F + 1) ? W + 2 : F + 1) + 1;
    localparam int SW   = RADW + 1;
    localparam int NW   = RADW + F;
    localparam int SQW  = (NW + 1) / 2;
    localparam int NPW  = 2 * SQW;
    localparam int REMW = SQW + 3;
    localparam int NUMW = W + 1;
    localparam int DW   = W + F + 2;
    localparam int VW   = SQW + 1;
    localparam int CW   = ((DW > VW + W) ? DW : VW + W) + 1;

    localparam logic signed [SW-1:0] ONE_S = SW'(1) << F;
    localparam logic [W-1:0] SMAX_U = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN_U = {1'b1, {(W-1){1'b0}}};

    // the pipeline never stalls
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // Stage A: pick the pivot, form the radicand and three numerators.
    // Numerator lane 0 feeds the component opposite the pivot pair
    // (w for a diagonal pivot, x for the w pivot); lanes 1 and 2 the rest.
    // ---------------------------------------------------------------
    logic                   a_valid_reg;
    sel_t                   a_sel_reg,  a_sel_next;
    logic                   a_deg_reg,  a_deg_next;
    logic [RADW-1:0]        a_rad_reg,  a_rad_next;
    logic signed [NUMW-1:0] a_num_reg  [LANES];
    logic signed [NUMW-1:0] a_num_next [LANES];

    always_comb
    begin
        logic signed [SW-1:0]   e00, e11, e22, trace, rad;
        logic signed [NUMW-1:0] nx, ny, nz, s01, s02, s12;
        e00 = SW'(r00);
        e11 = SW'(r11);
        e22 = SW'(r22);
        trace = e00 + e11 + e22;
        nx  = NUMW'(r21) - NUMW'(r12);
        ny  = NUMW'(r02) - NUMW'(r20);
        nz  = NUMW'(r10) - NUMW'(r01);
        s01 = NUMW'(r01) + NUMW'(r10);
        s02 = NUMW'(r02) + NUMW'(r20);
        s12 = NUMW'(r12) + NUMW'(r21);
        if (trace > 0)
        begin
            a_sel_next = SEL_W;
            rad = trace + ONE_S;
            a_num_next[0] = nx;
            a_num_next[1] = ny;
            a_num_next[2] = nz;
        end
        else if (r00 > r11 && r00 > r22)
        begin
            a_sel_next = SEL_X;
            rad = ONE_S + e00 - e11 - e22;
            a_num_next[0] = nx;
            a_num_next[1] = s01;
            a_num_next[2] = s02;
        end
        else if (r11 > r22)
        begin
            a_sel_next = SEL_Y;
            rad = ONE_S + e11 - e00 - e22;
            a_num_next[0] = ny;
            a_num_next[1] = s01;
            a_num_next[2] = s12;
        end
        else
        begin
            a_sel_next = SEL_Z;
            rad = ONE_S + e22 - e00 - e11;
            a_num_next[0] = nz;
            a_num_next[1] = s02;
            a_num_next[2] = s12;
        end
        a_deg_next = (rad <= 0);
        a_rad_next = a_deg_next ? '0 : rad[RADW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        a_sel_reg <= a_sel_next;
        a_deg_reg <= a_deg_next;
        a_rad_reg <= a_rad_next;
        for (int l = 0; l < LANES; l++)
            a_num_reg[l] <= a_num_next[l];
    end

    // ---------------------------------------------------------------
    // Square root: one root bit per stage, two radicand bits consumed.
    // ---------------------------------------------------------------
    logic                   sq_valid [SQW+1];
    sel_t                   sq_sel   [SQW+1];
    logic                   sq_deg   [SQW+1];
    logic [NPW-1:0]         sq_n     [SQW+1];
    logic [REMW-1:0]        sq_rem   [SQW+1];
    logic [SQW-1:0]         sq_root  [SQW+1];
    logic signed [NUMW-1:0] sq_num   [SQW+1][LANES];

    always_comb
    begin
        sq_valid[0] = a_valid_reg;
        sq_sel[0]   = a_sel_reg;
        sq_deg[0]   = a_deg_reg;
        sq_n[0]     = NPW'({a_rad_reg, {F{1'b0}}});
        sq_rem[0]   = '0;
        sq_root[0]  = '0;
        for (int l = 0; l < LANES; l++)
            sq_num[0][l] = a_num_reg[l];
    end

    for (genvar k = 0; k < SQW; k++)
    begin : g_sqrt
        logic [REMW-1:0] rem_sh, trial, rem_next;
        logic [SQW-1:0]  root_next;
        logic            valid_reg;

        always_comb
        begin
            rem_sh = {sq_rem[k][REMW-3:0], sq_n[k][NPW-1-2*k -: 2]};
            trial  = {1'b0, sq_root[k], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {sq_root[k][SQW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {sq_root[k][SQW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else
                valid_reg <= sq_valid[k];
        end

        always_ff @(posedge clk)
        begin
            sq_sel[k+1]  <= sq_sel[k];
            sq_deg[k+1]  <= sq_deg[k];
            sq_n[k+1]    <= sq_n[k];
            sq_rem[k+1]  <= rem_next;
            sq_root[k+1] <= root_next;
            for (int l = 0; l < LANES; l++)
                sq_num[k+1][l] <= sq_num[k][l];
        end

        assign sq_valid[k+1] = valid_reg;
    end

    // ---------------------------------------------------------------
    // Prep: pivot value, dividend, divisor and overflow per lane.
    // ---------------------------------------------------------------
    logic            p_valid_reg;
    sel_t            p_sel_reg;
    logic            p_deg_reg;
    logic [SQW-1:0]  p_piv_reg;
    logic            p_neg_reg [LANES];
    logic            p_ovf_reg [LANES];
    logic [CW-1:0]   p_d_reg   [LANES];
    logic [CW-1:0]   p_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= sq_valid[SQW];
    end

    always_ff @(posedge clk)
    begin
        logic [SQW-1:0]  s;
        logic [NUMW-1:0] mag;
        logic [CW-1:0]   dvd, dvs;
        s = (sq_root[SQW] == '0) ? SQW'(1) : sq_root[SQW];
        dvs = CW'({s, 1'b0});
        p_sel_reg <= sq_sel[SQW];
        p_deg_reg <= sq_deg[SQW];
        p_piv_reg <= SQW'((CW'(s) + CW'(1)) >> 1);
        p_v_reg   <= dvs;
        for (int l = 0; l < LANES; l++)
        begin
            mag = sq_num[SQW][l][NUMW-1] ? NUMW'(-sq_num[SQW][l]) : NUMW'(sq_num[SQW][l]);
            dvd = CW'({mag, {F{1'b0}}}) + CW'(s);
            p_neg_reg[l] <= sq_num[SQW][l][NUMW-1];
            p_ovf_reg[l] <= (dvd >= (dvs << W));
            p_d_reg[l]   <= dvd;
        end
    end

    // ---------------------------------------------------------------
    // Division: three restoring dividers, one quotient bit per stage.
    // ---------------------------------------------------------------
    logic           dv_valid [W+1];
    sel_t           dv_sel   [W+1];
    logic           dv_deg   [W+1];
    logic [SQW-1:0] dv_piv   [W+1];
    logic [CW-1:0]  dv_v     [W+1];
    logic           dv_neg   [W+1][LANES];
    logic           dv_ovf   [W+1][LANES];
    logic [CW-1:0]  dv_r     [W+1][LANES];
    logic [W-1:0]   dv_q     [W+1][LANES];

    always_comb
    begin
        dv_valid[0] = p_valid_reg;
        dv_sel[0]   = p_sel_reg;
        dv_deg[0]   = p_deg_reg;
        dv_piv[0]   = p_piv_reg;
        dv_v[0]     = p_v_reg;
        for (int l = 0; l < LANES; l++)
        begin
            dv_neg[0][l] = p_neg_reg[l];
            dv_ovf[0][l] = p_ovf_reg[l];
            dv_r[0][l]   = p_d_reg[l];
            dv_q[0][l]   = '0;
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_div
        logic valid_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else
                valid_reg <= dv_valid[k];
        end

        always_ff @(posedge clk)
        begin
            logic [CW-1:0] shv;
            shv = dv_v[k] << (W - 1 - k);
            dv_sel[k+1] <= dv_sel[k];
            dv_deg[k+1] <= dv_deg[k];
            dv_piv[k+1] <= dv_piv[k];
            dv_v[k+1]   <= dv_v[k];
            for (int l = 0; l < LANES; l++)
            begin
                dv_neg[k+1][l] <= dv_neg[k][l];
                dv_ovf[k+1][l] <= dv_ovf[k][l];
                if (dv_r[k][l] >= shv)
                begin
                    dv_r[k+1][l] <= dv_r[k][l] - shv;
                    dv_q[k+1][l] <= {dv_q[k][l][W-2:0], 1'b1};
                end
                else
                begin
                    dv_r[k+1][l] <= dv_r[k][l];
                    dv_q[k+1][l] <= {dv_q[k][l][W-2:0], 1'b0};
                end
            end
        end

        assign dv_valid[k+1] = valid_reg;
    end

    // ---------------------------------------------------------------
    // Output: apply signs, saturate, route lanes to components.
    // ---------------------------------------------------------------
    logic         done_reg;
    sel_t         out_sel_reg;
    logic [W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic         deg_reg;
    logic [W-1:0] lane_val [LANES];
    logic [W-1:0] piv_val;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (dv_neg[W][l])
                lane_val[l] = (dv_ovf[W][l] || dv_q[W][l] > SMIN_U) ? SMIN_U
                                                                    : W'(-dv_q[W][l]);
            else
                lane_val[l] = (dv_ovf[W][l] || dv_q[W][l] > SMAX_U) ? SMAX_U : dv_q[W][l];
        end
        piv_val = (CW'(dv_piv[W]) > CW'(SMAX_U)) ? SMAX_U : W'(dv_piv[W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid[W];
    end

    always_ff @(posedge clk)
    begin
        out_sel_reg <= dv_sel[W];
        deg_reg     <= dv_deg[W];
        if (dv_deg[W])
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= '0;
        end
        else
        begin
            case (dv_sel[W])
                SEL_W:
                begin
                    qw_reg <= piv_val;     qx_reg <= lane_val[0];
                    qy_reg <= lane_val[1]; qz_reg <= lane_val[2];
                end
                SEL_X:
                begin
                    qx_reg <= piv_val;     qw_reg <= lane_val[0];
                    qy_reg <= lane_val[1]; qz_reg <= lane_val[2];
                end
                SEL_Y:
                begin
                    qy_reg <= piv_val;     qw_reg <= lane_val[0];
                    qx_reg <= lane_val[1]; qz_reg <= lane_val[2];
                end
                default:
                begin
                    qz_reg <= piv_val;     qw_reg <= lane_val[0];
                    qx_reg <= lane_val[1]; qy_reg <= lane_val[2];
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign qx         = qx_reg;
    assign qy         = qy_reg;
    assign qz         = qz_reg;
    assign qw         = qw_reg;
    assign degenerate = deg_reg;

`ifndef SYNTHESIS
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> a_valid_reg)
        else $error("accepted word did not enter the first stage");
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (qx == '0 && qy == '0 && qz == '0 && qw == '0))
        else $error("degenerate result carries nonzero components");
    a_deg_branch: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_deg_reg) |-> (a_sel_reg != SEL_W))
        else $error("w pivot flagged degenerate");
    a_piv_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !degenerate && out_sel_reg == SEL_W) |-> !qw[W-1])
        else $error("w pivot came out negative");
`endif
endmodule
`default_nettype wire
